FILE: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared codes and field widths of the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

	// field widths of the command and result channels
	localparam int MODE_W   = 2;
	localparam int POS_W    = 6;
	localparam int DATA_W   = 32;
	localparam int INDEX_W  = 5;
	localparam int STATUS_W = 2;

	// command codes
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	// outcome codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/ple_cmd_if.sv
// ----------------------------------------------------------------------------
// ple_cmd_if
// Command channel: valid/ready with mode, position and data word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [ple_pkg::MODE_W-1:0]   mode;
	logic [ple_pkg::POS_W-1:0]    position;
	logic [ple_pkg::DATA_W-1:0]   data_word;

	modport source (output valid, output mode, output position, output data_word,
		input ready);
	modport sink (input valid, input mode, input position, input data_word,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ple_res_if.sv
// ----------------------------------------------------------------------------
// ple_res_if
// Result channel: valid/ready with one list entry per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_res_if;
	logic                          valid;
	logic                          ready;
	logic [ple_pkg::DATA_W-1:0]    entry_word;
	logic [ple_pkg::INDEX_W-1:0]   entry_index;
	logic                          is_empty;
	logic                          last;
	logic [ple_pkg::STATUS_W-1:0]  status;

	modport source (output valid, output entry_word, output entry_index,
		output is_empty, output last, output status, input ready);
	modport sink (input valid, input entry_word, input entry_index,
		input is_empty, input last, input status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ple_mem.sv
// ----------------------------------------------------------------------------
// ple_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_mem #(
	parameter int DEPTH     = 32,
	parameter int WIDTH     = 32,
	parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [ADDR_BITS-1:0] raddr,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY words with append, insert and remove at a
// 1-based position; the whole list is streamed out after every command.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                                           | transfer
//  --------+-----+--------------------------------------------------+---------
//  cmd     | in  | mode, position, data_word                        | 1 command
//  res     | out | entry_word, entry_index, is_empty, last, status  | 1 entry
//
// One command at a time, taken only in idle: the command is accepted, then for insert
// and remove the moved entries are shifted (each read, then written back one slot
// over), then the entries are listed in order (one empty marker for an empty list).
// Reset clears entry_count and control only; memory is read below entry_count.
// res.ready low stalls the listing; the last result may wait in the output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
	parameter int CAPACITY  = 32,
	parameter int WORD_BITS = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ple_cmd_if.sink    cmd,
	ple_res_if.source  res
);

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_FINISH,
		S_LIST
	} state_t;

	state_t state_q;

	// list state
	logic [CW-1:0] count_q;

	// shift sequencer
	logic [AW-1:0] ptr_q;        // next entry to read
	logic [CW-1:0] rem_q;        // reads still to issue
	logic          up_q;         // 1: remove (pull entries toward front)
	logic          ins_q;        // insert word after the shift
	logic [AW-1:0] at_q;
	logic [WORD_BITS-1:0] word_q;
	logic          wv_s1;        // write-back of last read pending
	logic [AW-1:0] waddr_s1;

	// listing
	logic [CW-1:0] list_q;       // next entry to read
	logic          pend_q;       // read data holds an entry not yet sent
	logic [AW-1:0] pend_idx_q;
	logic [ple_pkg::STATUS_W-1:0] status_q;

	// output register
	logic                          out_valid_q;
	logic [ple_pkg::DATA_W-1:0]    out_word_q;
	logic [ple_pkg::INDEX_W-1:0]   out_index_q;
	logic                          out_empty_q;
	logic                          out_last_q;
	logic [ple_pkg::STATUS_W-1:0]  out_status_q;

	// memory port
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] rd_data;

	// command decode
	logic                       cmd_fire;
	logic [ple_pkg::POS_W-1:0]  at6;
	logic [CMPW-1:0]            at_x;
	logic [CMPW-1:0]            cnt_x;
	logic                       full;
	logic [WORD_BITS-1:0]       word_in;

	logic out_free;
	logic move;
	logic issue_list;
	logic list_done;
	logic load_empty;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	// positions 0 and 1 both select the front
	assign at6     = (cmd.position == '0) ? '0 : cmd.position - 1'b1;
	assign at_x    = CMPW'(at6);
	assign cnt_x   = CMPW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));
	assign word_in = WORD_BITS'(cmd.data_word);

	// listing handshake: rd_data acts as a one-entry stage ahead of the output
	assign out_free   = !out_valid_q || res.ready;
	assign move       = (state_q == S_LIST) && pend_q && out_free;
	assign issue_list = (state_q == S_LIST) && (list_q != count_q) && (!pend_q || move);
	assign list_done  = (state_q == S_LIST) && (count_q != '0) && (list_q == count_q)
		&& (!pend_q || move);
	assign load_empty = (state_q == S_LIST) && (count_q == '0) && out_free;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		if (state_q == S_SHIFT && rem_q != '0) begin
			mem_re = 1'b1;
		end else if (issue_list) begin
			mem_re    = 1'b1;
			mem_raddr = AW'(list_q);
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = waddr_s1;
		mem_wdata = rd_data;
		if (cmd_fire && cmd.mode == ple_pkg::MODE_APPEND && !full) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(count_q);
			mem_wdata = word_in;
		end else if (state_q == S_SHIFT && wv_s1) begin
			mem_we = 1'b1;
		end else if (state_q == S_FINISH && ins_q) begin
			mem_we    = 1'b1;
			mem_waddr = at_q;
			mem_wdata = word_q;
		end
	end

	ple_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	// control state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			wv_s1       <= 1'b0;
			list_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			up_q        <= 1'b0;
			ins_q       <= 1'b0;
			status_q    <= ple_pkg::ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						list_q <= '0;
						case (cmd.mode)
							ple_pkg::MODE_APPEND: begin
								state_q <= S_LIST;
								if (full) begin
									status_q <= ple_pkg::ST_FULL;
								end else begin
									status_q <= ple_pkg::ST_DONE;
									count_q  <= count_q + CW'(1);
								end
							end
							ple_pkg::MODE_INSERT: begin
								if (at_x > cnt_x) begin
									status_q <= ple_pkg::ST_RANGE;
									state_q  <= S_LIST;
								end else if (full) begin
									status_q <= ple_pkg::ST_FULL;
									state_q  <= S_LIST;
								end else begin
									status_q <= ple_pkg::ST_DONE;
									rem_q    <= CW'(cnt_x - at_x);
									up_q     <= 1'b0;
									ins_q    <= 1'b1;
									count_q  <= count_q + CW'(1);
									state_q  <= S_SHIFT;
								end
							end
							ple_pkg::MODE_REMOVE: begin
								if (at_x >= cnt_x) begin
									status_q <= ple_pkg::ST_RANGE;
									state_q  <= S_LIST;
								end else begin
									status_q <= ple_pkg::ST_DONE;
									rem_q    <= CW'(cnt_x - at_x - CMPW'(1));
									up_q     <= 1'b1;
									ins_q    <= 1'b0;
									count_q  <= count_q - CW'(1);
									state_q  <= S_SHIFT;
								end
							end
							default: begin
								status_q <= ple_pkg::ST_RANGE;
								state_q  <= S_LIST;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// one read issued per cycle; its data is written back next cycle
					wv_s1 <= (rem_q != '0);
					if (rem_q != '0) begin
						rem_q <= rem_q - CW'(1);
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= S_LIST;
				end
				S_LIST: begin
					if (issue_list) begin
						list_q <= list_q + CW'(1);
						pend_q <= 1'b1;
					end else if (move) begin
						pend_q <= 1'b0;
					end
					if (list_done || load_empty) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (move || load_empty) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			at_q   <= AW'(at6);
			word_q <= word_in;
			if (cmd.mode == ple_pkg::MODE_REMOVE) begin
				ptr_q <= AW'(at_x + CMPW'(1));
			end else begin
				ptr_q <= AW'(count_q - CW'(1));
			end
		end else if (state_q == S_SHIFT && rem_q != '0) begin
			ptr_q <= up_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
			// entry read at ptr lands one slot over
			waddr_s1 <= up_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
		end

		if (issue_list) begin
			pend_idx_q <= AW'(list_q);
		end

		if (load_empty) begin
			out_word_q   <= '0;
			out_index_q  <= '0;
			out_empty_q  <= 1'b1;
			out_last_q   <= 1'b1;
			out_status_q <= status_q;
		end else if (move) begin
			out_word_q   <= ple_pkg::DATA_W'(rd_data);
			out_index_q  <= ple_pkg::INDEX_W'(pend_idx_q);
			out_empty_q  <= 1'b0;
			out_last_q   <= (CW'(pend_idx_q) + CW'(1) == count_q);
			out_status_q <= status_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.entry_word  = out_word_q;
	assign res.entry_index = out_index_q;
	assign res.is_empty    = out_empty_q;
	assign res.last        = out_last_q;
	assign res.status      = out_status_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ple_chk.sv
// ----------------------------------------------------------------------------
// ple_chk
// Port-level checks for the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cmd_valid,
	input wire logic                          cmd_ready,
	input wire logic                          res_valid,
	input wire logic                          res_ready,
	input wire logic [ple_pkg::DATA_W-1:0]    res_entry_word,
	input wire logic [ple_pkg::INDEX_W-1:0]   res_entry_index,
	input wire logic                          res_is_empty,
	input wire logic                          res_last,
	input wire logic [ple_pkg::STATUS_W-1:0]  res_status
);

	// stalled result stays valid and holds its word, index and last flag
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_entry_word)
			&& $stable(res_entry_index) && $stable(res_last))
		else $error("result changed while stalled");

	// one command at a time
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while busy");

	// empty marker is a lone final result at index zero
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_is_empty |-> res_last && res_entry_index == '0
			&& res_entry_word == '0)
		else $error("malformed empty result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_status == ple_pkg::ST_DONE || res_status == ple_pkg::ST_RANGE
			|| res_status == ple_pkg::ST_FULL)
		else $error("unknown status code");

endmodule

bind positional_list_engine ple_chk u_ple_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_entry_word  (res.entry_word),
	.res_entry_index (res.entry_index),
	.res_is_empty    (res.is_empty),
	.res_last        (res.last),
	.res_status      (res.status)
);

`default_nettype wire
